@@ rtl/smd_pkg.sv @@
// Shared constants and controller/datapath interface types for the sign-magnitude divider.
`timescale 1ns / 1ps

package smd_pkg;

  localparam int MAG_BITS = 96;
  localparam int FIELD_BITS = 96;
  localparam int LO_BITS = 64;
  localparam int HI_BITS = 32;
  localparam int CNT_W = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;
  localparam int IN_DATA_BITS = 200;
  localparam int OUT_DATA_BITS = 104;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
  } dp_stat_t;

endpackage

@@ rtl/smd_ctrl.sv @@
// Controller for the divider: accepts a word, sequences the divide steps, fills the output.
`timescale 1ns / 1ps

module smd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  smd_pkg::dp_stat_t  stat,
  output smd_pkg::dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [smd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic publish;

  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;
  assign publish = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load = accept;
    cmd.step = (state_r == S_RUN) && !stat.den_zero;
    cmd.publish = publish;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          cnt_nxt = smd_pkg::CNT_W'(smd_pkg::MAG_BITS - 1);
        end
      end
      S_RUN: begin
        if (stat.den_zero || (cnt_r == '0)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (publish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/smd_dp.sv @@
// Datapath for the divider: operand registers, restoring shift-subtract step, output register.
`timescale 1ns / 1ps

module smd_dp (
  input  logic                                clk,
  input  logic [smd_pkg::FIELD_BITS-1:0]      dividend_mag,
  input  logic                                dividend_neg,
  input  logic [smd_pkg::FIELD_BITS-1:0]      divisor_mag,
  input  logic                                divisor_neg,
  input  smd_pkg::dp_cmd_t                    cmd,
  output smd_pkg::dp_stat_t                   stat,
  output logic [smd_pkg::FIELD_BITS-1:0]      quotient_mag,
  output logic                                quotient_neg,
  output logic                                status
);

  localparam int MB = smd_pkg::MAG_BITS;
  localparam int FB = smd_pkg::FIELD_BITS;

  logic [MB-1:0] num_r, num_nxt;
  logic [MB-1:0] den_r, den_nxt;
  logic [MB-1:0] rem_r, rem_nxt;
  logic [MB-1:0] quo_r, quo_nxt;
  logic neg_r, neg_nxt;
  logic dz_r, dz_nxt;
  logic [FB-1:0] oq_r, oq_nxt;
  logic oneg_r, oneg_nxt;
  logic ost_r, ost_nxt;

  logic [MB+FB-1:0] num_ext, den_ext;
  logic [MB+FB-1:0] quo_ext;
  logic [MB:0] shifted;
  logic [MB+1:0] diff;
  logic ge;

  // Operands are fitted to the magnitude width: upper bits dropped or zeros added.
  assign num_ext = {{MB{1'b0}}, dividend_mag};
  assign den_ext = {{MB{1'b0}}, divisor_mag};
  assign quo_ext = {{FB{1'b0}}, quo_r};

  assign shifted = {rem_r, num_r[MB-1]};
  assign diff = {1'b0, shifted} - {2'b00, den_r};
  assign ge = !diff[MB+1];

  always_comb begin
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    neg_nxt = neg_r;
    dz_nxt = dz_r;
    oq_nxt = oq_r;
    oneg_nxt = oneg_r;
    ost_nxt = ost_r;
    if (cmd.load) begin
      num_nxt = num_ext[MB-1:0];
      den_nxt = den_ext[MB-1:0];
      rem_nxt = '0;
      quo_nxt = '0;
      neg_nxt = dividend_neg ^ divisor_neg;
      dz_nxt = (den_ext[MB-1:0] == '0);
    end else if (cmd.step) begin
      num_nxt = num_r << 1;
      rem_nxt = ge ? diff[MB-1:0] : shifted[MB-1:0];
      quo_nxt = {quo_r[MB-2:0], ge};
    end
    if (cmd.publish) begin
      oq_nxt = quo_ext[FB-1:0];
      oneg_nxt = neg_r;
      ost_nxt = dz_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    dz_r <= dz_nxt;
    oq_r <= oq_nxt;
    oneg_r <= oneg_nxt;
    ost_r <= ost_nxt;
  end

  assign stat.den_zero = dz_r;
  assign quotient_mag = oq_r;
  assign quotient_neg = oneg_r;
  assign status = ost_r;

endmodule

@@ rtl/signed_magnitude_divider_96.sv @@
// Top level of the sign-magnitude divider: stream ports, controller and datapath.
// One word is divided at a time by restoring shift-subtract division, one quotient bit per
// cycle from a single compare-and-subtract unit. A word passes through these steps from
// acceptance to a valid result: the operands load at the accepting edge, then one step is
// taken per magnitude bit, then the quotient moves into the output register once that
// register is empty or its result is being taken. A zero divisor skips the steps and returns
// with status set and a zero magnitude. The next word is accepted as soon as the result has
// moved to the output register, even if it is not yet taken.
`timescale 1ns / 1ps

module signed_magnitude_divider_96 (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // dividend_lo[63:0], dividend_hi[95:64], dividend_neg[96], divisor_lo[160:97],
  // divisor_hi[192:161], divisor_neg[193], zero fill above.
  input  logic [smd_pkg::IN_DATA_BITS-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // quotient_lo[63:0], quotient_hi[95:64], quotient_neg[96], status[97], zero fill above.
  output logic [smd_pkg::OUT_DATA_BITS-1:0]    out_tdata
);

  localparam int FB = smd_pkg::FIELD_BITS;

  smd_pkg::dp_cmd_t cmd;
  smd_pkg::dp_stat_t stat;
  logic [FB-1:0] dividend_mag;
  logic [FB-1:0] divisor_mag;
  logic [FB-1:0] quotient_mag;
  logic quotient_neg;
  logic status;

  assign dividend_mag = in_tdata[FB-1:0];
  assign divisor_mag = in_tdata[2*FB:FB+1];

  smd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  smd_dp u_dp (
    .clk          (clk),
    .dividend_mag (dividend_mag),
    .dividend_neg (in_tdata[FB]),
    .divisor_mag  (divisor_mag),
    .divisor_neg  (in_tdata[2*FB+1]),
    .cmd          (cmd),
    .stat         (stat),
    .quotient_mag (quotient_mag),
    .quotient_neg (quotient_neg),
    .status       (status)
  );

  assign out_tdata = {{(smd_pkg::OUT_DATA_BITS - FB - 2){1'b0}}, status, quotient_neg,
                      quotient_mag};

endmodule

@@ rtl/smd_checker.sv @@
// Port-level assertions for the sign-magnitude divider, bound to its top level.
`timescale 1ns / 1ps

module smd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [smd_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [smd_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // A division by zero always reports a zero magnitude.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[smd_pkg::FIELD_BITS + 1] |->
      out_tdata[smd_pkg::FIELD_BITS-1:0] == '0)
    else $error("division by zero with nonzero quotient");

  // Once a word is taken the block is busy and no new result appears at once.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !$rose(out_tvalid))
    else $error("divider not busy after accepting a word");

endmodule

bind signed_magnitude_divider_96 smd_checker u_smd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
